FILE: src/stbe_pkg.sv
// Package: payload, priority vector and register index types for the BPDU engine.
package stbe_pkg;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  rx_port;
    logic [63:0] bpdu_root;
    logic [31:0] bpdu_cost;
    logic [63:0] bpdu_sender;
    logic [15:0] bpdu_port;
  } in_t;

  typedef struct packed {
    logic [3:0]  tx_port;
    logic [63:0] tx_root;
    logic [31:0] tx_cost;
    logic [63:0] tx_sender;
    logic [15:0] tx_port_id;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [63:0] root;
    logic [31:0] cost;
    logic [63:0] sw;
    logic [15:0] dport;
  } vec_t;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIDGE_ID     = 3'd0,
    REG_ACTIVE_PORTS  = 3'd1,
    REG_PORT_PRIORITY = 3'd2,
    REG_LINK_COST     = 3'd3
  } reg_idx_t;

  localparam logic REQ_HELLO = 1'b1;

endpackage

FILE: src/spanning_tree_bpdu_engine.sv
// Top level: 802.1D config BPDU engine with a sequenced root port selection.
// One port vector is read per cycle through a single comparator. A better BPDU runs
// root selection, then designation, the designated scan and emission; a worse BPDU
// returns to idle, or draws a reply when it arrives on a designated port; a hello
// runs the designated scan and emission while the switch is root and hellos are
// enabled; output stalls can hold emission. After reset and after every write to a
// defined register an init sweep over min(MAX_PORTS,16) port entries runs with
// in_stall high. Beats leave through an output register in port order.
module spanning_tree_bpdu_engine #(
  parameter int MAX_PORTS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [stbe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [63:0]                        cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  stbe_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output stbe_pkg::out_t                     out_data
);
  import stbe_pkg::*;

  localparam int NP = (MAX_PORTS < 16) ? MAX_PORTS : 16;
  localparam int IW = (NP > 1) ? $clog2(NP) : 1;
  localparam int CW = $clog2(NP + 1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RXCMP, S_SELI, S_SELJ, S_ROOT, S_DES, S_MASK, S_EMIT
  } state_t;

  state_t st;

  logic [63:0] bridge_id;
  logic [4:0]  active_ports;
  logic [7:0]  port_priority;
  logic [15:0] link_cost;

  logic [63:0] switch_root;
  logic [31:0] switch_cost;
  logic        root_port_valid;
  logic [3:0]  root_port_index;
  logic        hello_active;

  vec_t port_vec [NP];

  in_t           inq;
  vec_t          cand;
  logic          found;
  logic [CW-1:0] idx;
  logic [CW-1:0] jdx;
  logic [NP-1:0] mask;
  logic [IW-1:0] e;

  logic [CW-1:0] n;
  logic [IW-1:0] rd_addr;
  vec_t          rv;
  logic [CW-1:0] rd_pos;
  logic          rd_des;
  logic          guard;
  vec_t          cmp_a, cmp_b;
  logic          cmp_lt;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  vec_t          wr_vec;
  logic [32:0]   cost_sum;
  logic [NP-1:0] mask_rest;
  logic          cfg_hit;
  logic          emit_fire;

  function automatic logic [15:0] own_id(input logic [7:0] prio, input logic [CW-1:0] i);
    logic [7:0] lb;
    lb = 8'(i) + 8'd1;
    return {prio, lb};
  endfunction

  always_comb begin
    if (active_ports == 5'd0) begin
      n = CW'(1);
    end else if (int'(active_ports) > NP) begin
      n = CW'(NP);
    end else begin
      n = CW'(active_ports);
    end
  end

  always_comb begin
    case (st)
      S_RXCMP: rd_pos = CW'(inq.rx_port);
      S_SELJ:  rd_pos = jdx;
      default: rd_pos = idx;
    endcase
    rd_addr = rd_pos[IW-1:0];
  end

  assign rv     = port_vec[rd_addr];
  assign rd_des = (rv.sw == bridge_id) && (rv.dport == own_id(port_priority, rd_pos));
  assign guard  = (switch_root == bridge_id) || root_port_valid;

  always_comb begin
    case (st)
      S_RXCMP: cmp_a = vec_t'{inq.bpdu_root, inq.bpdu_cost, inq.bpdu_sender, inq.bpdu_port};
      S_SELJ:  cmp_a = cand;
      default: cmp_a = vec_t'{switch_root, switch_cost, rv.sw, rv.dport};
    endcase
    cmp_b = rv;
  end

  stbe_vec_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .lt (cmp_lt)
  );

  assign cost_sum  = {1'b0, cand.cost} + 33'(link_cost);
  assign mask_rest = mask & ~(NP'(1) << e);
  assign cfg_hit   = cfg_valid && (cfg_index <= REG_LINK_COST);
  assign emit_fire = !cfg_hit && (st == S_EMIT) && (mask != '0) && mask[e] &&
                     (!out_valid || !out_stall);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_addr;
    wr_vec  = vec_t'{bridge_id, 32'd0, bridge_id, own_id(port_priority, idx)};
    case (st)
      S_INIT: begin
        wr_en = 1'b1;
      end
      S_RXCMP: begin
        wr_en  = cmp_lt;
        wr_vec = vec_t'{inq.bpdu_root, inq.bpdu_cost, inq.bpdu_sender, inq.bpdu_port};
      end
      S_DES: begin
        wr_en  = (idx != n) && (rd_des || cmp_lt);
        wr_vec = vec_t'{switch_root, switch_cost, bridge_id, own_id(port_priority, idx)};
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      port_vec[wr_addr] <= wr_vec;
    end
  end

  assign cfg_ready = 1'b1;
  assign in_stall  = (st != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st              <= S_INIT;
      bridge_id       <= '0;
      active_ports    <= 5'd16;
      port_priority   <= 8'd128;
      link_cost       <= 16'd1;
      switch_root     <= '0;
      switch_cost     <= '0;
      root_port_valid <= 1'b0;
      root_port_index <= '0;
      hello_active    <= 1'b1;
      idx             <= '0;
      jdx             <= '0;
      mask            <= '0;
      e               <= '0;
      found           <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_hit) begin
        case (cfg_index)
          REG_BRIDGE_ID:     bridge_id     <= cfg_data;
          REG_ACTIVE_PORTS:  active_ports  <= cfg_data[4:0];
          REG_PORT_PRIORITY: port_priority <= cfg_data[7:0];
          REG_LINK_COST:     link_cost     <= cfg_data[15:0];
          default:           bridge_id     <= bridge_id;
        endcase
        if (cfg_index == REG_BRIDGE_ID) begin
          switch_root <= cfg_data;
        end else begin
          switch_root <= bridge_id;
        end
        switch_cost     <= '0;
        root_port_valid <= 1'b0;
        root_port_index <= '0;
        hello_active    <= 1'b1;
        idx             <= '0;
        st              <= S_INIT;
      end else begin
        case (st)
          S_INIT: begin
            idx <= idx + CW'(1);
            if (idx == CW'(NP - 1)) begin
              st <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (in_valid) begin
              inq <= in_data;
              if (in_data.req_type == REQ_HELLO) begin
                if (hello_active && (switch_root == bridge_id)) begin
                  idx  <= '0;
                  mask <= '0;
                  st   <= S_MASK;
                end
              end else if (int'(in_data.rx_port) < int'(n)) begin
                st <= S_RXCMP;
              end
            end
          end
          S_RXCMP: begin
            if (cmp_lt) begin
              idx <= '0;
              st  <= S_SELI;
            end else if (rd_des && guard) begin
              mask <= NP'(1) << rd_addr;
              e    <= '0;
              st   <= S_EMIT;
            end else begin
              st <= S_IDLE;
            end
          end
          S_SELI: begin
            if (idx == n) begin
              found <= 1'b0;
              st    <= S_ROOT;
            end else if (rd_des) begin
              idx <= idx + CW'(1);
            end else begin
              cand <= rv;
              jdx  <= '0;
              st   <= S_SELJ;
            end
          end
          S_SELJ: begin
            if (jdx == n) begin
              found           <= 1'b1;
              root_port_index <= 4'(idx);
              st              <= S_ROOT;
            end else if ((jdx != idx) && !rd_des && !cmp_lt) begin
              idx <= idx + CW'(1);
              st  <= S_SELI;
            end else begin
              jdx <= jdx + CW'(1);
            end
          end
          S_ROOT: begin
            root_port_valid <= found;
            if (found) begin
              switch_root <= cand.root;
              switch_cost <= cost_sum[32] ? 32'hFFFF_FFFF : cost_sum[31:0];
              if ((switch_root == bridge_id) && (cand.root != bridge_id)) begin
                hello_active <= 1'b0;
              end
              if ((switch_root != bridge_id) && (cand.root == bridge_id)) begin
                hello_active <= 1'b1;
              end
            end else begin
              root_port_index <= '0;
              switch_root     <= bridge_id;
              switch_cost     <= '0;
              if (switch_root != bridge_id) begin
                hello_active <= 1'b1;
              end
            end
            idx <= '0;
            st  <= S_DES;
          end
          S_DES: begin
            if (idx == n) begin
              idx  <= '0;
              mask <= '0;
              st   <= S_MASK;
            end else begin
              idx <= idx + CW'(1);
            end
          end
          S_MASK: begin
            if (idx == n) begin
              e  <= '0;
              st <= S_EMIT;
            end else begin
              mask[rd_addr] <= rd_des && guard;
              idx           <= idx + CW'(1);
            end
          end
          S_EMIT: begin
            if (mask == '0) begin
              st <= S_IDLE;
            end else if (mask[e]) begin
              if (emit_fire) begin
                out_data.tx_port    <= 4'(e);
                out_data.tx_root    <= switch_root;
                out_data.tx_cost    <= switch_cost;
                out_data.tx_sender  <= bridge_id;
                out_data.tx_port_id <= own_id(port_priority, CW'(e));
                out_data.last       <= (mask_rest == '0);
                mask                <= mask_rest;
                e                   <= e + IW'(1);
              end
            end else begin
              e <= e + IW'(1);
            end
          end
          default: st <= S_IDLE;
        endcase
      end
    end
  end

  a_cfg_init: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && (cfg_index <= REG_LINK_COST)) |=> (st == S_INIT))
    else $error("register write did not start init sweep");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled output beat changed");

  a_hello_quiet: assert property (@(posedge clk) disable iff (rst)
    (st == S_IDLE && in_valid && in_data.req_type == REQ_HELLO && !cfg_valid &&
     switch_root != bridge_id) |=> (st == S_IDLE))
    else $error("hello acted while not root");

endmodule

FILE: src/stbe_vec_cmp.sv
// Shared lexicographic priority vector comparator (root, cost, switch, port).
module stbe_vec_cmp (
  input  stbe_pkg::vec_t a,
  input  stbe_pkg::vec_t b,
  output logic           lt
);
  import stbe_pkg::*;

  always_comb begin
    if (a.root != b.root) begin
      lt = a.root < b.root;
    end else if (a.cost != b.cost) begin
      lt = a.cost < b.cost;
    end else if (a.sw != b.sw) begin
      lt = a.sw < b.sw;
    end else begin
      lt = a.dport < b.dport;
    end
  end

endmodule

FILE: sim/spanning_tree_bpdu_engine_tb.sv
// Testbench: spanning tree BPDU engine driven with directed and random BPDUs, checked beat by beat.
`timescale 1ns / 100ps

module spanning_tree_bpdu_engine_tb;
  import stbe_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 400;

  class bpdu_scoreboard;
    logic [63:0] bridge;
    logic [4:0]  ports_reg;
    logic [7:0]  prio;
    logic [15:0] lcost;
    logic [63:0] p_root[16];
    logic [31:0] p_cost[16];
    logic [63:0] p_sw[16];
    logic [15:0] p_dp[16];
    logic [63:0] sw_root;
    logic [31:0] sw_cost;
    bit          rp_valid;
    int          rp_idx;
    bit          hello_on;
    out_t        tx_q[$];
    int          errors;

    function new();
      bridge = '0;
      ports_reg = 5'd16;
      prio = 8'd128;
      lcost = 16'd1;
      errors = 0;
      restart();
    endfunction

    function logic [15:0] port_id(int i);
      return {prio, 8'(i + 1)};
    endfunction

    function void restart();
      for (int i = 0; i < 16; i++) begin
        p_root[i] = bridge;
        p_cost[i] = '0;
        p_sw[i] = bridge;
        p_dp[i] = port_id(i);
      end
      sw_root = bridge;
      sw_cost = '0;
      rp_valid = 0;
      rp_idx = 0;
      hello_on = 1;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
      case (idx)
        REG_BRIDGE_ID: bridge = data;
        REG_ACTIVE_PORTS: ports_reg = data[4:0];
        REG_PORT_PRIORITY: prio = data[7:0];
        REG_LINK_COST: lcost = data[15:0];
        default: return;
      endcase
      restart();
    endfunction

    function int port_count();
      if (ports_reg < 1) return 1;
      if (ports_reg > 16) return 16;
      return ports_reg;
    endfunction

    function bit designated(int i);
      return p_sw[i] == bridge && p_dp[i] == port_id(i);
    endfunction

    function bit port_beats(int a, int b);
      return {p_root[a], p_cost[a], p_sw[a], p_dp[a]} < {p_root[b], p_cost[b], p_sw[b], p_dp[b]};
    endfunction

    function void reselect(int n);
      bit found, ok, was_root, now_root;
      logic [32:0] c;
      found = 0;
      was_root = sw_root == bridge;
      for (int i = 0; i < n && !found; i++) begin
        if (!designated(i)) begin
          ok = 1;
          for (int j = 0; j < n; j++)
            if (j != i && !designated(j) && !port_beats(i, j)) ok = 0;
          if (ok) begin
            found = 1;
            rp_idx = i;
          end
        end
      end
      if (found) begin
        c = {1'b0, p_cost[rp_idx]} + 33'(lcost);
        rp_valid = 1;
        sw_root = p_root[rp_idx];
        sw_cost = c[32] ? 32'hFFFF_FFFF : c[31:0];
      end else begin
        rp_valid = 0;
        rp_idx = 0;
        sw_root = bridge;
        sw_cost = '0;
      end
      now_root = sw_root == bridge;
      if (was_root && !now_root) hello_on = 0;
      if (!was_root && now_root) hello_on = 1;
      for (int i = 0; i < n; i++)
        if (!designated(i) &&
            {sw_root, sw_cost, p_sw[i], p_dp[i]} < {p_root[i], p_cost[i], p_sw[i], p_dp[i]}) begin
          p_sw[i] = bridge;
          p_dp[i] = port_id(i);
        end
      for (int i = 0; i < n; i++)
        if (designated(i)) begin
          p_root[i] = sw_root;
          p_cost[i] = sw_cost;
        end
    endfunction

    function void send_on(int i, ref out_t beats[$]);
      out_t b;
      if (sw_root != bridge && !rp_valid) return;
      if (beats.size() >= 16) return;
      b.tx_port = 4'(i);
      b.tx_root = sw_root;
      b.tx_cost = sw_cost;
      b.tx_sender = bridge;
      b.tx_port_id = port_id(i);
      b.last = 1'b0;
      beats.push_back(b);
    endfunction

    function void note_input(in_t x);
      out_t beats[$];
      int n;
      int p;
      n = port_count();
      p = x.rx_port;
      if (x.req_type == REQ_HELLO) begin
        if (hello_on && sw_root == bridge)
          for (int i = 0; i < n; i++) if (designated(i)) send_on(i, beats);
      end else if (p < n) begin
        if ({x.bpdu_root, x.bpdu_cost, x.bpdu_sender, x.bpdu_port} <
            {p_root[p], p_cost[p], p_sw[p], p_dp[p]}) begin
          p_root[p] = x.bpdu_root;
          p_cost[p] = x.bpdu_cost;
          p_sw[p] = x.bpdu_sender;
          p_dp[p] = x.bpdu_port;
          reselect(n);
          for (int i = 0; i < n; i++) if (designated(i)) send_on(i, beats);
        end else if (designated(p)) begin
          send_on(p, beats);
        end
      end
      if (beats.size() > 0) beats[beats.size() - 1].last = 1'b1;
      foreach (beats[k]) tx_q.push_back(beats[k]);
    endfunction

    function void check_result(out_t got);
      out_t exp;
      if (tx_q.size() == 0) begin
        $error("unexpected beat tx_port=%0d", got.tx_port);
        errors++;
        return;
      end
      exp = tx_q.pop_front();
      if (got.tx_port !== exp.tx_port) begin
        $error("tx_port exp %0d got %0d", exp.tx_port, got.tx_port);
        errors++;
      end
      if (got.tx_root !== exp.tx_root) begin
        $error("tx_root exp %h got %h", exp.tx_root, got.tx_root);
        errors++;
      end
      if (got.tx_cost !== exp.tx_cost) begin
        $error("tx_cost exp %h got %h", exp.tx_cost, got.tx_cost);
        errors++;
      end
      if (got.tx_sender !== exp.tx_sender) begin
        $error("tx_sender exp %h got %h", exp.tx_sender, got.tx_sender);
        errors++;
      end
      if (got.tx_port_id !== exp.tx_port_id) begin
        $error("tx_port_id exp %h got %h", exp.tx_port_id, got.tx_port_id);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last exp %b got %b", exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  bpdu_scoreboard sb = new();
  bit quiet = 0;
  int stall_left = 0;
  int cycles = 0;

  spanning_tree_bpdu_engine dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst || quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic set_config(logic [63:0] bid, logic [4:0] np, logic [7:0] pr, logic [15:0] lc);
    write_reg(REG_BRIDGE_ID, bid);
    write_reg(REG_PORT_PRIORITY, 64'(pr));
    write_reg(REG_LINK_COST, 64'(lc));
    write_reg(REG_ACTIVE_PORTS, 64'(np));
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_item(in_t x);
    in_valid <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (in_stall);
    sb.note_input(x);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.tx_q.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic in_t bpdu(int port, logic [63:0] r, logic [31:0] c, logic [63:0] s,
                               logic [15:0] dp);
    in_t x;
    x.req_type = ~REQ_HELLO;
    x.rx_port = 4'(port);
    x.bpdu_root = r;
    x.bpdu_cost = c;
    x.bpdu_sender = s;
    x.bpdu_port = dp;
    return x;
  endfunction

  function automatic in_t hello();
    in_t x;
    x = '0;
    x.req_type = REQ_HELLO;
    x.rx_port = 4'($urandom);
    return x;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_t random_item();
    in_t x;
    int n;
    int k;
    n = sb.port_count();
    k = $urandom_range(0, 99);
    if (k < 15) return hello();
    if (k < 30) begin
      x.req_type = ~REQ_HELLO;
      x.rx_port = 4'($urandom);
      x.bpdu_root = rand64();
      x.bpdu_cost = $urandom;
      x.bpdu_sender = rand64();
      x.bpdu_port = 16'($urandom);
      return x;
    end
    x.req_type = ~REQ_HELLO;
    x.rx_port = (k < 35) ? 4'($urandom) : 4'($urandom_range(0, n - 1));
    x.bpdu_root = sb.bridge + 64'($signed($urandom_range(0, 6)) - 4);
    x.bpdu_cost = (k < 40) ? 32'hFFFF_FFFF - $urandom_range(0, 3) : $urandom_range(0, 20);
    x.bpdu_sender = sb.bridge + 64'($signed($urandom_range(0, 4)) - 2);
    x.bpdu_port = {8'($urandom_range(127, 129)), 8'($urandom_range(1, 4))};
    return x;
  endfunction

  initial begin
    logic [63:0] br;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_item(hello());
    send_item(bpdu(0, 64'd0, 32'd0, 64'd0, 16'd0));
    drain();

    br = 64'h8000_0000_0000_0010;
    set_config(br, 5'd4, 8'd128, 16'd10);
    write_reg(REG_UNUSED, rand64());
    cfg_valid <= 1'b0;
    @(negedge clk);
    send_item(hello());
    send_item(bpdu(7, 64'd0, 32'd0, 64'd0, 16'd0));
    send_item(bpdu(0, '1, '1, '1, '1));
    send_item(bpdu(1, 64'd5, 32'hFFFF_FFFF, 64'd9, 16'h8002));
    send_item(hello());
    send_item(bpdu(2, 64'd5, 32'hFFFF_FFFF, 64'd9, 16'h8002));
    send_item(hello());
    send_item(bpdu(3, 64'd0, 32'd0, 64'd0, 16'd0));
    send_item(bpdu(0, 64'd0, 32'd0, 64'd0, 16'd1));
    send_item(bpdu(3, '1, '1, '1, '1));
    send_item(hello());
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(rand64(), 5'd4, 8'($urandom), 16'($urandom_range(1, 65535)));
        1: set_config('1, 5'd16, 8'd255, 16'd65535);
        2: set_config('0, 5'd1, 8'd0, 16'd1);
        3: set_config(rand64(), 5'd0, 8'd128, 16'd100);
        4: set_config(rand64(), 5'd31, 8'($urandom), 16'($urandom_range(1, 65535)));
        default: begin
          set_config(rand64(), 5'd5, 8'd128, 16'd1);
          quiet = 1;
        end
      endcase
      for (int i = 0; i < 24; i++) send_item(random_item());
      drain();
    end

    if (sb.errors == 0 && sb.tx_q.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: files.f
src/stbe_pkg.sv
src/stbe_vec_cmp.sv
src/spanning_tree_bpdu_engine.sv
sim/spanning_tree_bpdu_engine_tb.sv
